// File: sv/bbcr_pkg.sv
// ----------------------------------------------------------------------------
// bbcr_pkg
// Shared constants, status and opcode codes, and the request/response
// structs that pass between the coverage recorder's sequencer, its shared
// add/subtract unit and its two memories.
// ----------------------------------------------------------------------------
package bbcr_pkg;

	// Storage sizes
	localparam int BITMAP_BYTES = 8192;
	localparam int BM_AW        = $clog2(BITMAP_BYTES);
	localparam int LOG_DEPTH    = 4096;
	localparam int LOG_AW       = $clog2(LOG_DEPTH);
	localparam int CNT_W        = LOG_AW + 1;

	// Field widths
	localparam int ADDR_W  = 32;
	localparam int SIZE_W  = 16;
	localparam int IDX_W   = 12;
	localparam int STAT_W  = 3;
	localparam int OP_W    = 2;
	localparam int BCNT_W  = 13;
	localparam int CFG_IW  = 1;

	// Opcodes
	localparam logic [OP_W-1:0] OP_TRACE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] ST_NEW     = 3'd0;
	localparam logic [STAT_W-1:0] ST_COVERED = 3'd1;
	localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
	localparam logic [STAT_W-1:0] ST_READ_OK = 3'd4;
	localparam logic [STAT_W-1:0] ST_BADIDX  = 3'd5;
	localparam logic [STAT_W-1:0] ST_CLEARED = 3'd6;

	// Configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_REGION_BEGIN = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_REGION_END   = 1'b1;

	localparam logic [ADDR_W-1:0] REGION_BEGIN_RST = 32'd0;
	localparam logic [ADDR_W-1:0] REGION_END_RST   = 32'd131071;

	// Shared add/subtract unit
	typedef struct packed {
		logic              sub;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] res;
		logic              borrow;
		logic              zero;
	} alu_rsp_t;

	// Hit bitmap port
	typedef struct packed {
		logic [BM_AW-1:0] raddr;
		logic             we;
		logic [BM_AW-1:0] waddr;
		logic [7:0]       wdata;
	} bm_req_t;

	// Block log port
	typedef struct packed {
		logic [LOG_AW-1:0] raddr;
		logic              we;
		logic [LOG_AW-1:0] waddr;
		logic [ADDR_W-1:0] woff;
		logic [SIZE_W-1:0] wsize;
	} log_req_t;

endpackage

// File: sv/bbcr_alu.sv
// ----------------------------------------------------------------------------
// bbcr_alu
// Shared 32-bit add/subtract unit. Gives the result, the borrow of a
// subtraction (carry of an addition) and a zero flag.
// ----------------------------------------------------------------------------
module bbcr_alu (
	input  bbcr_pkg::alu_req_t req,
	output bbcr_pkg::alu_rsp_t rsp
);
	import bbcr_pkg::*;

	logic [ADDR_W:0] sum;
	logic [ADDR_W-1:0] b_op;

	// Invert and add one for subtraction
	always_comb begin
		b_op = req.sub ? ~req.b : req.b;
		sum  = {1'b0, req.a} + {1'b0, b_op} + (ADDR_W+1)'(req.sub);
		rsp.res    = sum[ADDR_W-1:0];
		rsp.borrow = req.sub ? ~sum[ADDR_W] : sum[ADDR_W];
		rsp.zero   = (sum[ADDR_W-1:0] == '0);
	end

endmodule

// File: sv/bbcr_bitmap.sv
// ----------------------------------------------------------------------------
// bbcr_bitmap
// Hit bitmap memory, one byte per row. One write and one registered read
// per cycle.
// ----------------------------------------------------------------------------
module bbcr_bitmap (
	input  logic                clk,
	input  bbcr_pkg::bm_req_t   req,
	output logic [7:0]          rd_q
);
	import bbcr_pkg::*;

	logic [7:0] mem [BITMAP_BYTES];

	// Write and read the row array
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_q <= mem[req.raddr];
	end

endmodule

// File: sv/bbcr_log.sv
// ----------------------------------------------------------------------------
// bbcr_log
// Log of recorded blocks: offset and size per entry. One write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module bbcr_log (
	input  logic                          clk,
	input  bbcr_pkg::log_req_t            req,
	output logic [bbcr_pkg::ADDR_W-1:0]   off_q,
	output logic [bbcr_pkg::SIZE_W-1:0]   size_q
);
	import bbcr_pkg::*;

	logic [ADDR_W-1:0] off_mem  [LOG_DEPTH];
	logic [SIZE_W-1:0] size_mem [LOG_DEPTH];

	// Append entry and read back
	always_ff @(posedge clk) begin
		if (req.we) begin
			off_mem[req.waddr]  <= req.woff;
			size_mem[req.waddr] <= req.wsize;
		end
		off_q  <= off_mem[req.raddr];
		size_q <= size_mem[req.raddr];
	end

endmodule

// File: sv/basic_block_coverage_recorder_core.sv
// ----------------------------------------------------------------------------
// basic_block_coverage_recorder_core
// Records each executed basic block of a traced region once, in a hit
// bitmap (one bit per halfword) and a log of offset/size entries.
//
//   channel  dir  handshake            payload
//   cfg      in   cfg_we               cfg_index, cfg_data
//   in       in   in_valid / in_stall  opcode, block_address, block_bytes,
//                                      entry_index
//   out      out  out_valid / out_stall status, entry_offset, entry_bytes,
//                                      block_count
//
// A trace item sets its bits by read-modify-write, one bitmap byte at a
// time, through the single bitmap port; a trace outside the region and a
// read item write nothing to the bitmap.
// A clear item and reset both sweep all BITMAP_BYTES (8192) bitmap bytes
// one byte a cycle, in_stall high throughout; a clear item then reports
// ST_CLEARED.
// One item is in work at a time; in_stall is low only while idle.
// The result sits in an output register until taken; a stalled output
// holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module basic_block_coverage_recorder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bbcr_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [bbcr_pkg::ADDR_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bbcr_pkg::OP_W-1:0]     opcode,
	input  logic [bbcr_pkg::ADDR_W-1:0]   block_address,
	input  logic [bbcr_pkg::SIZE_W-1:0]   block_bytes,
	input  logic [bbcr_pkg::IDX_W-1:0]    entry_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bbcr_pkg::STAT_W-1:0]   status,
	output logic [bbcr_pkg::ADDR_W-1:0]   entry_offset,
	output logic [bbcr_pkg::SIZE_W-1:0]   entry_bytes,
	output logic [bbcr_pkg::BCNT_W-1:0]   block_count
);
	import bbcr_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LO, S_HI, S_TEST, S_SETRD, S_SETWR, S_RD, S_RDOUT, S_DONE
	} state_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  begin_q, end_q;
	logic [ADDR_W-1:0]  addr_q, off_q, ex_q;
	logic [SIZE_W-1:0]  bytes_q;
	logic [IDX_W-1:0]   idx_q;
	logic               below_q, last_q, lt_q, clr_op_q;
	logic [BM_AW-1:0]   b_q, clr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [STAT_W-1:0]  res_st_q;
	logic [ADDR_W-1:0]  res_off_q;
	logic [SIZE_W-1:0]  res_bytes_q;
	logic               out_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [ADDR_W-1:0]  entry_offset_q;
	logic [SIZE_W-1:0]  entry_bytes_q;
	logic [BCNT_W-1:0]  block_count_q;

	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	bm_req_t            bm_req;
	log_req_t           log_req;
	logic [7:0]         bm_rd;
	logic [ADDR_W-1:0]  log_off;
	logic [SIZE_W-1:0]  log_size;

	logic [ADDR_W-2:0]  first;
	logic               first_in;
	logic [BM_AW-1:0]   first_byte;
	logic [SIZE_W-2:0]  halves;
	logic [BM_AW:0]     b_inc;
	logic               covered, full, record;
	logic [2:0]         lo;
	logic [7:0]         lo_mask, hi_mask, set_mask;

	localparam logic [BM_AW-1:0] BM_LAST = BM_AW'(BITMAP_BYTES - 1);

	// Decode the traced block
	always_comb begin
		first      = off_q[ADDR_W-1:1];
		first_in   = (first >> 3) < (ADDR_W-1)'(BITMAP_BYTES);
		first_byte = first[BM_AW+2:3];
		halves     = bytes_q[SIZE_W-1:1];
		b_inc      = {1'b0, b_q} + (BM_AW+1)'(1);
		covered    = first_in && bm_rd[first[2:0]];
		full       = (cnt_q == CNT_W'(LOG_DEPTH));
		record     = (state_q == S_TEST) && !covered && !full;
	end

	// Build the bit mask for the current bitmap byte
	always_comb begin
		lo       = (b_q == first_byte) ? first[2:0] : 3'd0;
		lo_mask  = 8'hff << lo;
		hi_mask  = (last_q && (ex_q[2:0] != 3'd0)) ?
			(8'hff >> (4'd8 - {1'b0, ex_q[2:0]})) : 8'hff;
		set_mask = lo_mask & hi_mask;
	end

	// Steer the shared unit
	always_comb begin
		alu_req = '{sub: 1'b1, a: '0, b: '0};
		case (state_q)
			S_LO: begin
				alu_req = '{sub: 1'b1, a: addr_q, b: begin_q};
			end
			S_HI: begin
				alu_req = '{sub: 1'b1, a: end_q, b: addr_q};
			end
			S_TEST: begin
				alu_req = '{sub: 1'b0, a: {1'b0, first}, b: ADDR_W'(halves)};
			end
			S_SETRD: begin
				alu_req = '{sub: 1'b1, a: ex_q, b: ADDR_W'({b_inc, 3'b000})};
			end
			S_RD: begin
				alu_req = '{sub: 1'b1, a: ADDR_W'(idx_q), b: ADDR_W'(cnt_q)};
			end
			default: begin
				alu_req = '{sub: 1'b1, a: '0, b: '0};
			end
		endcase
	end

	// Drive bitmap and log ports
	always_comb begin
		bm_req.raddr = (state_q == S_HI) ? first_byte : b_q;
		bm_req.we    = (state_q == S_CLR) || (state_q == S_SETWR);
		bm_req.waddr = (state_q == S_CLR) ? clr_q : b_q;
		bm_req.wdata = (state_q == S_CLR) ? 8'h00 : (bm_rd | set_mask);

		log_req.raddr = LOG_AW'(idx_q);
		log_req.we    = record;
		log_req.waddr = cnt_q[LOG_AW-1:0];
		log_req.woff  = off_q;
		log_req.wsize = bytes_q;
	end

	bbcr_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	bbcr_bitmap u_bitmap (
		.clk  (clk),
		.req  (bm_req),
		.rd_q (bm_rd)
	);

	bbcr_log u_log (
		.clk    (clk),
		.req    (log_req),
		.off_q  (log_off),
		.size_q (log_size)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_q <= REGION_BEGIN_RST;
			end_q   <= REGION_END_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REGION_BEGIN: begin_q <= cfg_data;
				CFG_REGION_END:   end_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			clr_op_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the result once transferred, unless a new one loads
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (clr_q == BM_LAST) begin
						clr_q <= '0;
						if (clr_op_q) begin
							res_st_q    <= ST_CLEARED;
							res_off_q   <= '0;
							res_bytes_q <= '0;
							state_q     <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						clr_q <= clr_q + BM_AW'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						addr_q  <= block_address;
						bytes_q <= block_bytes;
						idx_q   <= entry_index;
						case (opcode)
							OP_TRACE: state_q <= S_LO;
							OP_READ:  state_q <= S_RD;
							OP_CLEAR: begin
								cnt_q    <= '0;
								clr_op_q <= 1'b1;
								state_q  <= S_CLR;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_LO: begin
					off_q   <= alu_rsp.res;
					below_q <= alu_rsp.borrow;
					state_q <= S_HI;
				end
				S_HI: begin
					if (below_q || alu_rsp.borrow) begin
						res_st_q    <= ST_OUTSIDE;
						res_off_q   <= '0;
						res_bytes_q <= '0;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_TEST;
					end
				end
				S_TEST: begin
					res_off_q   <= off_q;
					res_bytes_q <= bytes_q;
					if (covered) begin
						res_st_q <= ST_COVERED;
						state_q  <= S_DONE;
					end else if (full) begin
						res_st_q <= ST_FULL;
						state_q  <= S_DONE;
					end else begin
						res_st_q <= ST_NEW;
						cnt_q    <= cnt_q + CNT_W'(1);
						ex_q     <= alu_rsp.res;
						if ((halves != '0) && first_in) begin
							b_q     <= first_byte;
							state_q <= S_SETRD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SETRD: begin
					last_q  <= alu_rsp.borrow || alu_rsp.zero;
					state_q <= S_SETWR;
				end
				S_SETWR: begin
					if (last_q || (b_q == BM_LAST)) begin
						state_q <= S_DONE;
					end else begin
						b_q     <= b_inc[BM_AW-1:0];
						state_q <= S_SETRD;
					end
				end
				S_RD: begin
					lt_q    <= alu_rsp.borrow;
					state_q <= S_RDOUT;
				end
				S_RDOUT: begin
					if (lt_q) begin
						res_st_q    <= ST_READ_OK;
						res_off_q   <= log_off;
						res_bytes_q <= log_size;
					end else begin
						res_st_q    <= ST_BADIDX;
						res_off_q   <= '0;
						res_bytes_q <= '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						status_q       <= res_st_q;
						entry_offset_q <= res_off_q;
						entry_bytes_q  <= res_bytes_q;
						block_count_q  <= BCNT_W'(cnt_q);
						clr_op_q       <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign entry_offset = entry_offset_q;
	assign entry_bytes  = entry_bytes_q;
	assign block_count  = block_count_q;

	// A newly recorded block always leaves a nonzero count
	a_new_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_NEW)) |-> (block_count != '0))
		else $error("new block reported with zero count");

	// A clear empties the log at once and blocks further input
	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (opcode == OP_CLEAR)) |=> (in_stall && (cnt_q == '0)))
		else $error("clear did not zero the count");

	// Results without an entry carry zero offset and size
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((status == ST_OUTSIDE) || (status == ST_BADIDX) ||
			(status == ST_CLEARED))) |-> ((entry_offset == '0) && (entry_bytes == '0)))
		else $error("nonzero payload on empty result");

endmodule
